>>> src/sensor_moving_average_monitor_macros.svh
// assertion macros for the sensor moving average monitor
// included by the files that carry concurrent assertions; no other dependencies
`ifndef SENSOR_MOVING_AVERAGE_MONITOR_MACROS_SVH
`define SENSOR_MOVING_AVERAGE_MONITOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sma assertion failed");

// next-cycle implication, disabled during reset
`define SMA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sma assertion failed");

`endif

>>> src/sma_pkg.sv
// shared types, codes and constants of the sensor moving average monitor
// no dependencies
package sma_pkg;

   // default sizes
   localparam int TABLE_ENTRIES_DEF = 32;
   localparam int WINDOW_DEF        = 4;

   // field widths
   localparam int DATA_W    = 16;
   localparam int ID_W      = 16;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 1;

   // item operations after classification
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER = 1'd1;

   typedef struct packed {
      logic [1:0]               mode;
      logic [ID_W-1:0]          probe_id;
      logic [ID_W-1:0]          room_id;
      logic signed [DATA_W-1:0] sample_value;
      logic [TIME_W-1:0]        timestamp;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [ID_W-1:0]          room_of_sensor;
      logic signed [DATA_W-1:0] average;
      logic [TIME_W-1:0]        last_modified;
      logic                     too_high;
      logic                     too_low;
   } rsp_type;

   typedef struct packed {
      logic [1:0]               op;
      logic [ID_W-1:0]          probe_id;
      logic [ID_W-1:0]          room_id;
      logic signed [DATA_W-1:0] sample_value;
      logic [TIME_W-1:0]        timestamp;
   } queue_item_type;

endpackage

>>> src/sma_front.sv
// front end: accepts items, classifies the mode and queues them for the back end
// depends on sma_pkg
module sma_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  sma_pkg::req_type        req_data,
   output logic                    req_stall,
   output logic                    head_valid,
   output sma_pkg::queue_item_type head_item,
   input  logic                    pop
);
   import sma_pkg::*;

   queue_item_type queue_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;
   queue_item_type item_class;

   // classify: the unused mode code is served as a query
   always_comb begin
      item_class.probe_id     = req_data.probe_id;
      item_class.room_id      = req_data.room_id;
      item_class.sample_value = req_data.sample_value;
      item_class.timestamp    = req_data.timestamp;
      unique case (req_data.mode)
         OP_LOAD:   item_class.op = OP_LOAD;
         OP_SAMPLE: item_class.op = OP_SAMPLE;
         default:   item_class.op = OP_QUERY;
      endcase
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = queue_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_class;
      end
   end

endmodule

>>> src/sma_back.sv
// back end: table lookup, window update, averaging and result register
// depends on sma_pkg and sensor_moving_average_monitor_macros.svh
`include "sensor_moving_average_monitor_macros.svh"

module sma_back #(
   parameter int TABLE_ENTRIES = sma_pkg::TABLE_ENTRIES_DEF,
   parameter int WINDOW        = sma_pkg::WINDOW_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  sma_pkg::queue_item_type head_item,
   output logic                    pop,
   input  logic signed [15:0]      upper_limit,
   input  logic signed [15:0]      lower_limit,
   output logic                    rsp_valid,
   output sma_pkg::rsp_type        rsp_data,
   input  logic                    rsp_stall
);
   import sma_pkg::*;

   localparam int SLOT_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int HELD_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W    = $clog2(WINDOW + 1);
   localparam int WIN_DEPTH = TABLE_ENTRIES * WINDOW;
   localparam int WADDR_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int SUM_W     = DATA_W + $clog2(WINDOW + 1);
   // reciprocal of the window length, exact for every sum magnitude
   localparam int RECIP_SH  = SUM_W + 4;
   localparam int RECIP_W   = RECIP_SH + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
      ((longint'(1) << RECIP_SH) + longint'(WINDOW) - 1) / longint'(WINDOW));

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_ACT  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   // table memories
   logic [ID_W-1:0]          id_mem   [TABLE_ENTRIES];
   logic [ID_W-1:0]          room_mem [TABLE_ENTRIES];
   logic signed [DATA_W-1:0] avg_mem  [TABLE_ENTRIES];
   logic [TIME_W-1:0]        time_mem [TABLE_ENTRIES];
   logic [FILL_W-1:0]        fill_mem [TABLE_ENTRIES];
   logic [PTR_W-1:0]         ptr_mem  [TABLE_ENTRIES];
   logic signed [DATA_W-1:0] win_mem  [WIN_DEPTH];

   logic [ID_W-1:0]          id_q, room_q;
   logic signed [DATA_W-1:0] avg_q, win_q;
   logic [TIME_W-1:0]        time_q;
   logic [FILL_W-1:0]        fill_q, fill_next;
   logic [PTR_W-1:0]         ptr_q, ptr_next;

   // sequencer registers
   logic [2:0]               state_ff, state_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [HELD_W-1:0]        held_ff, held_in;
   logic                     found_ff, found_in;
   queue_item_type           cur_ff, cur_in;
   logic [1:0]               res_status_ff, res_status_in;
   logic [ID_W-1:0]          res_room_ff, res_room_in;
   logic signed [DATA_W-1:0] res_avg_ff, res_avg_in;
   logic [TIME_W-1:0]        res_time_ff, res_time_in;
   logic [FILL_W-1:0]        k_ff, k_in;
   logic                     rd_v_ff, rd_v_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]         dq_ff, dq_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // write controls
   logic                     new_we, room_we, smp_we, avg_we;
   logic signed [DATA_W-1:0] avg_wdata;
   logic [SLOT_W-1:0]        held_slot, wr_slot;
   logic [WADDR_W-1:0]       win_base, win_waddr, win_raddr;
   logic [DATA_W-1:0]        quot;
   logic                     res_ok;

   // check terms
   logic                     full_rsp, table_full, load_act;

   assign held_slot = held_ff[SLOT_W-1:0];
   assign wr_slot   = new_we ? held_slot : slot_ff;
   assign win_base  = WADDR_W'(slot_ff) * WADDR_W'(WINDOW);
   assign win_waddr = win_base + WADDR_W'(ptr_q);
   assign win_raddr = win_base + WADDR_W'(k_ff);

   // window pointer and fill count after a sample
   assign ptr_next  = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
   assign fill_next = (fill_q == FILL_W'(WINDOW)) ? fill_q : fill_q + 1'b1;

   // quotient magnitude from the reciprocal product
   assign quot      = prod_ff[RECIP_SH +: DATA_W];

   assign res_ok    = (res_status_ff == STATUS_OK);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      held_in       = held_ff;
      found_in      = found_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_room_in   = res_room_ff;
      res_avg_in    = res_avg_ff;
      res_time_in   = res_time_ff;
      k_in          = k_ff;
      rd_v_in       = 1'b0;
      acc_in        = acc_ff;
      dq_in         = dq_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      pop           = 1'b0;
      new_we        = 1'b0;
      room_we       = 1'b0;
      smp_we        = 1'b0;
      avg_we        = 1'b0;
      avg_wdata     = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               cur_in   = head_item;
               slot_in  = '0;
               found_in = 1'b0;
               state_in = (held_ff == '0) ? S_ACT : S_SCAN;
            end
         end
         S_SCAN: begin
            // one table entry compared per cycle
            if (id_q == cur_ff.probe_id) begin
               found_in = 1'b1;
               state_in = S_ACT;
            end else if (HELD_W'(slot_ff) + 1'b1 < held_ff) begin
               slot_in = slot_ff + 1'b1;
            end else begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            res_status_in = STATUS_OK;
            state_in      = S_DONE;
            if (!found_ff) begin
               res_room_in = '0;
               res_avg_in  = '0;
               res_time_in = '0;
               if (cur_ff.op == OP_LOAD) begin
                  if (held_ff == HELD_W'(TABLE_ENTRIES)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     new_we      = 1'b1;
                     held_in     = held_ff + 1'b1;
                     res_room_in = cur_ff.room_id;
                  end
               end else begin
                  res_status_in = STATUS_UNKNOWN;
               end
            end else begin
               case (cur_ff.op)
                  OP_LOAD: begin
                     room_we     = 1'b1;
                     res_room_in = cur_ff.room_id;
                     res_avg_in  = avg_q;
                     res_time_in = time_q;
                  end
                  OP_SAMPLE: begin
                     smp_we      = 1'b1;
                     res_room_in = room_q;
                     res_time_in = cur_ff.timestamp;
                     if (fill_next == FILL_W'(WINDOW)) begin
                        k_in     = '0;
                        acc_in   = '0;
                        state_in = S_SUM;
                     end else begin
                        avg_we     = 1'b1;
                        res_avg_in = '0;
                     end
                  end
                  default: begin
                     res_room_in = room_q;
                     res_avg_in  = avg_q;
                     res_time_in = time_q;
                  end
               endcase
            end
         end
         S_SUM: begin
            // read the window one sample a cycle and accumulate
            if (k_ff != FILL_W'(WINDOW)) begin
               k_in    = k_ff + 1'b1;
               rd_v_in = 1'b1;
            end
            if (rd_v_ff) begin
               acc_in = acc_ff + SUM_W'(win_q);
            end
            if (k_ff == FILL_W'(WINDOW) && !rd_v_ff) begin
               neg_in   = acc_ff[SUM_W-1];
               dq_in    = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // magnitude times the reciprocal of the window length
            prod_in  = PROD_W'(dq_ff) * PROD_W'(RECIP);
            state_in = S_FIN;
         end
         S_FIN: begin
            // sign restored, truncation toward zero
            avg_we     = 1'b1;
            avg_wdata  = neg_ff ? -quot : quot;
            res_avg_in = avg_wdata;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = res_status_ff;
               rsp_data_in.room_of_sensor = res_room_ff;
               rsp_data_in.average        = res_avg_ff;
               rsp_data_in.last_modified  = res_time_ff;
               rsp_data_in.too_high       = res_ok && (res_avg_ff > upper_limit);
               rsp_data_in.too_low        = res_ok && (res_avg_ff < lower_limit);
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      found_ff      <= found_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_room_ff   <= res_room_in;
      res_avg_ff    <= res_avg_in;
      res_time_ff   <= res_time_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      dq_ff         <= dq_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // table memories, read at the next slot address
   always_ff @(posedge clock) begin
      if (new_we) begin
         id_mem[wr_slot] <= cur_ff.probe_id;
      end
      if (new_we || room_we) begin
         room_mem[wr_slot] <= cur_ff.room_id;
      end
      if (new_we || avg_we) begin
         avg_mem[wr_slot] <= new_we ? '0 : avg_wdata;
      end
      if (new_we || smp_we) begin
         time_mem[wr_slot] <= new_we ? '0 : cur_ff.timestamp;
         fill_mem[wr_slot] <= new_we ? '0 : fill_next;
         ptr_mem[wr_slot]  <= new_we ? '0 : ptr_next;
      end
      id_q   <= id_mem[slot_in];
      room_q <= room_mem[slot_in];
      avg_q  <= avg_mem[slot_in];
      time_q <= time_mem[slot_in];
      fill_q <= fill_mem[slot_in];
      ptr_q  <= ptr_mem[slot_in];
   end

   // sample window memory
   always_ff @(posedge clock) begin
      if (smp_we) begin
         win_mem[win_waddr] <= cur_ff.sample_value;
      end
      win_q <= win_mem[win_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign full_rsp   = rsp_valid_ff && (rsp_data_ff.status == STATUS_FULL);
   assign table_full = (held_ff == HELD_W'(TABLE_ENTRIES));
   assign load_act   = (state_ff == S_ACT) && (cur_ff.op == OP_LOAD);

   // checks
   `SMA_ASSERT_IMP(a_held_bound, clock, reset, 1'b1, held_ff <= HELD_W'(TABLE_ENTRIES))
   `SMA_ASSERT_IMP(a_full_when_held, clock, reset, full_rsp, table_full)
   `SMA_ASSERT_NXT(a_held_on_load, clock, reset, !load_act, held_ff == $past(held_ff))

endmodule

>>> src/sensor_moving_average_monitor.sv
// sensor moving average monitor top level: limit registers, front queue, back sequencer
// per item: id scan (0 to held ids compared), act, then the registered result
// a sample that leaves the window full adds summing, scale and sign
// one item at a time in the back, which is held while a result stalls
// reset (synchronous, active high) empties the table and loads the default limits
// depends on sma_pkg, sma_front and sma_back
module sensor_moving_average_monitor #(
   parameter int TABLE_ENTRIES = sma_pkg::TABLE_ENTRIES_DEF,
   parameter int WINDOW        = sma_pkg::WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  sma_pkg::req_type                req_data,
   output logic                            req_stall,
   output logic                            rsp_valid,
   output sma_pkg::rsp_type                rsp_data,
   input  logic                            rsp_stall,
   input  logic                            csr_we,
   input  logic [sma_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sma_pkg::DATA_W-1:0]      csr_wdata
);
   import sma_pkg::*;

   logic signed [DATA_W-1:0] upper_limit_ff, upper_limit_in;
   logic signed [DATA_W-1:0] lower_limit_ff, lower_limit_in;
   logic                     head_valid;
   queue_item_type           head_item;
   logic                     pop;

   // limit register writes
   always_comb begin
      upper_limit_in = upper_limit_ff;
      lower_limit_in = lower_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_UPPER: upper_limit_in = csr_wdata;
            CSR_LOWER: lower_limit_in = csr_wdata;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_limit_ff <= 16'sd7680;
         lower_limit_ff <= 16'sd2560;
      end else begin
         upper_limit_ff <= upper_limit_in;
         lower_limit_ff <= lower_limit_in;
      end
   end

   sma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   sma_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .WINDOW        (WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .upper_limit (upper_limit_ff),
      .lower_limit (lower_limit_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

endmodule
